// ----- hw/rtl/lsra_pkg.sv -----
// Package for the linear scan register assigner.
// Holds the fixed result field widths and the command struct sent to the allocator.
// No dependencies.
`default_nettype none

package lsra_pkg;

    // Fixed widths of the result fields.
    localparam int INDEX_W    = 6;
    localparam int REG_W      = 6;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 2;

    // Command from the scan sequencer to the register allocator.
    typedef struct packed {
        logic             take;       // claim the lowest free register
        logic             give_back;  // return give_reg to the free map
        logic [REG_W-1:0] give_reg;
        logic             clear;      // mark every register free again
    } lsra_alloc_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lsra_table.sv -----
// Interval storage for the linear scan register assigner: start, end and
// register memories sharing one registered read address.
// Depends on nothing but its parameters.
`default_nettype none

module lsra_table #(
    parameter int DEPTH = 64,
    parameter int POS_W = 10,
    parameter int RW    = 6
) (
    input  wire logic                     aclk,
    input  wire logic                     ld_en,
    input  wire logic [$clog2(DEPTH)-1:0] ld_addr,
    input  wire logic [POS_W-1:0]         ld_start,
    input  wire logic [POS_W-1:0]         ld_end,
    input  wire logic                     rg_we,
    input  wire logic [RW-1:0]            rg_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [POS_W-1:0]         rd_start,
    output logic      [POS_W-1:0]         rd_end,
    output logic      [RW-1:0]            rd_reg
);

    logic [POS_W-1:0] start_mem [DEPTH];
    logic [POS_W-1:0] end_mem   [DEPTH];
    logic [RW-1:0]    reg_mem   [DEPTH];

    // Intervals are written at load time, one per transfer.
    always_ff @(posedge aclk) begin
        if (ld_en) begin
            start_mem[ld_addr] <= ld_start;
            end_mem[ld_addr]   <= ld_end;
        end
    end

    // The register memory is written at the read address during the scan.
    always_ff @(posedge aclk) begin
        if (rg_we) begin
            reg_mem[rd_addr] <= rg_data;
        end
    end

    // Registered read of all three memories.
    always_ff @(posedge aclk) begin
        rd_start <= start_mem[rd_addr];
        rd_end   <= end_mem[rd_addr];
        rd_reg   <= reg_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lsra_alloc.sv -----
// Register allocator for the linear scan register assigner: free map and
// lowest-free-register encoder, shared by every interval visit.
// Depends on lsra_pkg.
`default_nettype none

module lsra_alloc #(
    parameter int REG_COUNT = 64
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire lsra_pkg::lsra_alloc_cmd_t cmd,
    output logic [lsra_pkg::REG_W-1:0]  free_reg
);
    import lsra_pkg::*;

    localparam int RIDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic [REG_COUNT-1:0] free_map_reg;
    logic [REG_COUNT-1:0] free_map_next;
    logic [RIDX_W-1:0]    low_idx;

    // Lowest set bit of the free map.
    always_comb begin
        low_idx = '0;
        for (int i = REG_COUNT - 1; i >= 0; i--) begin
            if (free_map_reg[i]) begin
                low_idx = RIDX_W'(i);
            end
        end
    end

    assign free_reg = REG_W'(low_idx);

    // Claim or return one register per cycle, or mark every register free on clear.
    always_comb begin
        free_map_next = free_map_reg;
        if (cmd.clear) begin
            free_map_next = '1;
        end else if (cmd.take) begin
            free_map_next[low_idx] = 1'b0;
        end else if (cmd.give_back) begin
            free_map_next[cmd.give_reg[RIDX_W-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_map_reg <= '1;
        end else begin
            free_map_reg <= free_map_next;
        end
    end

`ifndef SYNTHESIS
    // A claim always finds a free register.
    a_take_has_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> (free_map_reg != '0))
        else $error("register claimed with an empty free map");

    // One interval is visited at a time, so claim and return never coincide.
    a_take_xor_give: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.take && cmd.give_back))
        else $error("register claimed and returned in the same cycle");

    // A returned register must have been in use.
    a_give_was_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.give_back && !cmd.clear) |-> !free_map_reg[cmd.give_reg[RIDX_W-1:0]])
        else $error("returned register was already free");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/linear_scan_register_assign.sv -----
// Linear scan register assigner. Intervals [start, end) are loaded one per
// transfer until the transfer marked last in s_tlast. The block then scans
// positions 0 to the greatest end, visiting every stored interval at each
// position through one shared allocator; each visit is a table read, then
// an update. Results follow in load order; each is read from the tables,
// loaded into the result register and held until m_tready takes it. No
// input is taken from the last load until the final result has been
// transferred. Intervals beyond MAX_INTERVALS are dropped and reported in
// the overflow flag.
// Depends on lsra_pkg, lsra_table and lsra_alloc.
`default_nettype none

module linear_scan_register_assign #(
    parameter int MAX_INTERVALS = 64,
    parameter int POSITION_BITS = 10
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    // Input intervals.
    input  wire logic s_tvalid,
    output logic      s_tready,
    // tdata: interval_start, interval_end, zero padding (lowest bit first).
    input  wire logic [((2*POSITION_BITS+7)/8)*8-1:0] s_tdata,
    // tlast: is_last.
    input  wire logic s_tlast,
    // Results.
    output logic      m_tvalid,
    input  wire logic m_tready,
    // tdata: interval_index, assigned_register, zero padding (lowest bit first).
    output logic [lsra_pkg::M_TDATA_W-1:0] m_tdata,
    // tuser: was_assigned, overflowed (lowest bit first).
    output logic [lsra_pkg::M_TUSER_W-1:0] m_tuser,
    // tlast: last_result.
    output logic      m_tlast
);
    import lsra_pkg::*;

    localparam int IDX_W = $clog2(MAX_INTERVALS);
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int P_W   = POSITION_BITS;

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_SREAD = 6'b000010,
        ST_SEVAL = 6'b000100,
        ST_EREAD = 6'b001000,
        ST_ELOAD = 6'b010000,
        ST_EWAIT = 6'b100000
    } lsra_state_t;

    lsra_state_t          state_reg, state_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic [P_W-1:0]       p_reg, p_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [P_W-1:0]       gend_reg, gend_next;
    logic                 drop_reg, drop_next;
    logic [MAX_INTERVALS-1:0] live_reg, live_next;
    logic [MAX_INTERVALS-1:0] ever_reg, ever_next;
    logic                 m_valid_reg, m_valid_next;

    logic [INDEX_W-1:0]   out_idx_reg;
    logic [REG_W-1:0]     out_reg_reg;
    logic                 out_was_reg;
    logic                 out_ovf_reg;
    logic                 out_last_reg;

    logic [P_W-1:0]       in_start;
    logic [P_W-1:0]       in_end;
    logic                 s_xfer;
    logic                 m_xfer;
    logic                 has_room;
    logic                 k_is_final;

    logic [P_W-1:0]       rd_start;
    logic [P_W-1:0]       rd_end;
    logic [REG_W-1:0]     rd_reg;
    logic [REG_W-1:0]     free_reg;
    logic                 pos_hit;
    logic                 cur_live;
    logic                 grab;
    logic                 let_go;
    lsra_alloc_cmd_t      alloc_cmd;

    assign in_start   = s_tdata[P_W-1:0];
    assign in_end     = s_tdata[2*P_W-1:P_W];
    assign s_tready   = (state_reg == ST_LOAD);
    assign s_xfer     = s_tvalid && s_tready;
    assign m_xfer     = m_valid_reg && m_tready;
    assign has_room   = (count_reg < CNT_W'(MAX_INTERVALS));
    assign k_is_final = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);

    // Visit decision for the interval read out of the tables.
    assign pos_hit  = (p_reg >= rd_start) && (p_reg < rd_end);
    assign cur_live = live_reg[k_reg];
    assign grab     = (state_reg == ST_SEVAL) && pos_hit && !cur_live;
    assign let_go   = (state_reg == ST_SEVAL) && !pos_hit && cur_live;

    lsra_table #(
        .DEPTH (MAX_INTERVALS),
        .POS_W (P_W),
        .RW    (REG_W)
    ) u_table (
        .aclk     (aclk),
        .ld_en    (s_xfer && has_room),
        .ld_addr  (count_reg[IDX_W-1:0]),
        .ld_start (in_start),
        .ld_end   (in_end),
        .rg_we    (grab),
        .rg_data  (free_reg),
        .rd_addr  (k_reg),
        .rd_start (rd_start),
        .rd_end   (rd_end),
        .rd_reg   (rd_reg)
    );

    always_comb begin
        alloc_cmd.take      = grab;
        alloc_cmd.give_back = let_go;
        alloc_cmd.give_reg  = rd_reg;
        alloc_cmd.clear     = (state_reg == ST_EWAIT) && m_xfer && k_is_final;
    end

    lsra_alloc #(
        .REG_COUNT (MAX_INTERVALS)
    ) u_alloc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (alloc_cmd),
        .free_reg (free_reg)
    );

    // Sequencer: load, scan positions by intervals, then emit results.
    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        p_next       = p_reg;
        count_next   = count_reg;
        gend_next    = gend_reg;
        drop_next    = drop_reg;
        live_next    = live_reg;
        ever_next    = ever_reg;
        m_valid_next = m_valid_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_xfer) begin
                    if (has_room) begin
                        count_next = count_reg + CNT_W'(1);
                        if (in_end > gend_reg) begin
                            gend_next = in_end;
                        end
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (s_tlast) begin
                        k_next     = '0;
                        p_next     = '0;
                        state_next = ST_SREAD;
                    end
                end
            end
            ST_SREAD: begin
                state_next = ST_SEVAL;
            end
            ST_SEVAL: begin
                if (grab) begin
                    live_next[k_reg] = 1'b1;
                    ever_next[k_reg] = 1'b1;
                end else if (let_go) begin
                    live_next[k_reg] = 1'b0;
                end
                if (k_is_final) begin
                    k_next = '0;
                    if (p_reg == gend_reg) begin
                        state_next = ST_EREAD;
                    end else begin
                        p_next     = p_reg + P_W'(1);
                        state_next = ST_SREAD;
                    end
                end else begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = ST_SREAD;
                end
            end
            ST_EREAD: begin
                state_next = ST_ELOAD;
            end
            ST_ELOAD: begin
                m_valid_next = 1'b1;
                state_next   = ST_EWAIT;
            end
            ST_EWAIT: begin
                if (m_xfer) begin
                    m_valid_next = 1'b0;
                    if (k_is_final) begin
                        k_next     = '0;
                        count_next = '0;
                        gend_next  = '0;
                        drop_next  = 1'b0;
                        live_next  = '0;
                        ever_next  = '0;
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = ST_EREAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            k_reg       <= '0;
            p_reg       <= '0;
            count_reg   <= '0;
            gend_reg    <= '0;
            drop_reg    <= 1'b0;
            live_reg    <= '0;
            ever_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            p_reg       <= p_next;
            count_reg   <= count_next;
            gend_reg    <= gend_next;
            drop_reg    <= drop_next;
            live_reg    <= live_next;
            ever_reg    <= ever_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result register, loaded once the register memory read is back.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_ELOAD) begin
            out_idx_reg  <= INDEX_W'(k_reg);
            out_reg_reg  <= ever_reg[k_reg] ? rd_reg : '0;
            out_was_reg  <= ever_reg[k_reg];
            out_ovf_reg  <= drop_reg;
            out_last_reg <= k_is_final;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - INDEX_W - REG_W){1'b0}}, out_reg_reg, out_idx_reg};
    assign m_tuser  = {out_ovf_reg, out_was_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // Loading and result delivery never overlap.
    a_no_load_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // The stored count never exceeds the table depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_INTERVALS))
        else $error("interval count beyond table depth");

    // Between sets no interval holds a register.
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> (live_reg == '0))
        else $error("live interval left over while loading");

    // A scan only runs on a non-empty set.
    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SREAD) |-> (count_reg != '0))
        else $error("scan started with no stored interval");
`endif

endmodule

`default_nettype wire

// ----- tb/linear_scan_register_assign_test.sv -----
`timescale 1ns / 100ps
// Testbench for linear_scan_register_assign: streams sets of live intervals into the
// block and checks every register assignment against a behavioral predictor or a hand-written result.
// Depends on lsra_pkg and the linear_scan_register_assign RTL.
module linear_scan_register_assign_test;
    import lsra_pkg::*;

    localparam int POS_W        = 10;
    localparam int TABLE_SIZE   = 64;
    localparam int S_TDATA_W    = ((2*POS_W+7)/8)*8;
    localparam int RANDOM_ITEMS = 230;
    // Allowed run without a transfer; well above the slowest scan here.
    localparam int STALL_LIMIT  = 50000;
    localparam int DRAIN_CYCLES = 40;

    typedef logic [POS_W-1:0] pos_t;

    // One result of the block, split into its fields.
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [REG_W-1:0]   phys_reg;
        logic               was_assigned;
        logic               overflowed;
        logic               last_result;
    } assignment_t;

    // One row of the directed stimulus. Rows with known_result set close a
    // one-interval set whose result is written out by hand.
    typedef struct {
        pos_t        start_pos;
        pos_t        end_pos;
        bit          last;
        bit          known_result;
        assignment_t result;
    } directed_row_t;

    typedef enum {SET_NORMAL, SET_WIDE, SET_FULL, SET_OVERFLOW} set_kind_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;

    // Intervals of the set being loaded, as the block stores them.
    pos_t        loaded_starts[$];
    pos_t        loaded_ends[$];
    bit          loaded_dropped = 1'b0;
    assignment_t pending_assignments[$];

    int error_count    = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int quiet_cycles   = 0;

    linear_scan_register_assign #(
        .MAX_INTERVALS(TABLE_SIZE),
        .POSITION_BITS(POS_W)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // Clock with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Scan the loaded set from position 0 to its greatest end and queue one
    // expected assignment per stored interval, in load order.
    function automatic void predict_assignments();
        logic [TABLE_SIZE-1:0] live;
        logic [TABLE_SIZE-1:0] ever;
        logic [TABLE_SIZE-1:0] free_map;
        logic [REG_W-1:0]      held [TABLE_SIZE];
        pos_t                  greatest;
        int                    count;
        assignment_t           item;
        live     = '0;
        ever     = '0;
        free_map = '1;
        greatest = '0;
        count    = loaded_starts.size();
        foreach (loaded_ends[k])
            if (loaded_ends[k] > greatest) greatest = loaded_ends[k];
        for (int p = 0; p <= greatest; p++) begin
            for (int k = 0; k < count; k++) begin
                if (p >= loaded_starts[k] && p < loaded_ends[k]) begin
                    if (!live[k]) begin
                        // Claim the lowest free register.
                        for (int r = 0; r < TABLE_SIZE; r++) begin
                            if (free_map[r]) begin
                                held[k] = REG_W'(r);
                                free_map[r] = 1'b0;
                                break;
                            end
                        end
                        live[k] = 1'b1;
                        ever[k] = 1'b1;
                    end
                end else if (live[k]) begin
                    free_map[held[k]] = 1'b1;
                    live[k] = 1'b0;
                end
            end
        end
        for (int k = 0; k < count; k++) begin
            item.index        = INDEX_W'(k);
            item.phys_reg     = ever[k] ? held[k] : '0;
            item.was_assigned = ever[k];
            item.overflowed   = loaded_dropped;
            item.last_result  = (k + 1 == count);
            pending_assignments.push_back(item);
        end
    endfunction

    // Track one accepted interval; the last one of a set triggers the scan when predicted is set.
    function automatic void load_interval(pos_t s, pos_t e, bit last, bit predicted);
        if (loaded_starts.size() < TABLE_SIZE) begin
            loaded_starts.push_back(s);
            loaded_ends.push_back(e);
        end else begin
            loaded_dropped = 1'b1;
        end
        if (last) begin
            if (predicted) predict_assignments();
            loaded_starts.delete();
            loaded_ends.delete();
            loaded_dropped = 1'b0;
        end
    endfunction

    function automatic directed_row_t interval_row(pos_t s, pos_t e, bit last,
                                                   bit known = 1'b0, bit was = 1'b0);
        directed_row_t row;
        row.start_pos    = s;
        row.end_pos      = e;
        row.last         = last;
        row.known_result = known;
        row.result       = '{index: '0, phys_reg: '0, was_assigned: was,
                             overflowed: 1'b0, last_result: 1'b1};
        return row;
    endfunction

    // Idling for each quarter of the random part.
    function automatic void set_idling(int items_sent);
        case (items_sent * 4 / RANDOM_ITEMS)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 77; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 77; end
            default: begin src_idle_pct = 23; sink_stall_pct = 23; end
        endcase
    endfunction

    // Offer one interval and hold it until the transfer completes.
    task automatic send_interval(pos_t s, pos_t e, bit last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-2*POS_W){1'b0}}, e, s};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Receiver readiness, redrawn every cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Compare every result transfer with the oldest expected assignment.
    always @(posedge aclk) begin : check_results
        assignment_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_assignments.size() == 0) begin
                $error("unexpected result: interval_index %0d", m_tdata[INDEX_W-1:0]);
                error_count++;
            end else begin
                want = pending_assignments.pop_front();
                if (m_tdata[INDEX_W-1:0] !== want.index) begin
                    $error("interval_index: expected %0d, actual %0d",
                           want.index, m_tdata[INDEX_W-1:0]);
                    error_count++;
                end
                if (m_tdata[INDEX_W+REG_W-1:INDEX_W] !== want.phys_reg) begin
                    $error("assigned_register: expected %0d, actual %0d",
                           want.phys_reg, m_tdata[INDEX_W+REG_W-1:INDEX_W]);
                    error_count++;
                end
                if (m_tuser[0] !== want.was_assigned) begin
                    $error("was_assigned: expected %0d, actual %0d",
                           want.was_assigned, m_tuser[0]);
                    error_count++;
                end
                if (m_tuser[1] !== want.overflowed) begin
                    $error("overflowed: expected %0d, actual %0d",
                           want.overflowed, m_tuser[1]);
                    error_count++;
                end
                if (m_tlast !== want.last_result) begin
                    $error("last_result: expected %0d, actual %0d",
                           want.last_result, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus: reset, directed sets, then random sets.
    initial begin : stimulus
        directed_row_t directed_rows[$];
        set_kind_t     kind;
        pos_t          s;
        pos_t          e;
        int            count;
        int            span;
        int            items_sent;
        int            set_no;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Single intervals at the extremes, including empty ones.
        directed_rows.push_back(interval_row(10'd0, 10'd0, 1'b1, 1'b1, 1'b0));
        directed_rows.push_back(interval_row(10'd0, 10'd1023, 1'b1, 1'b1, 1'b1));
        directed_rows.push_back(interval_row(10'd1023, 10'd1023, 1'b1, 1'b1, 1'b0));
        directed_rows.push_back(interval_row(10'd1023, 10'd0, 1'b1, 1'b1, 1'b0));
        directed_rows.push_back(interval_row(10'd5, 10'd4, 1'b1, 1'b1, 1'b0));
        directed_rows.push_back(interval_row(10'd1022, 10'd1023, 1'b1, 1'b1, 1'b1));
        // Staggered overlaps so that registers are freed and reused.
        directed_rows.push_back(interval_row(10'd0, 10'd4, 1'b0));
        directed_rows.push_back(interval_row(10'd2, 10'd6, 1'b0));
        directed_rows.push_back(interval_row(10'd4, 10'd8, 1'b0));
        directed_rows.push_back(interval_row(10'd0, 10'd10, 1'b0));
        directed_rows.push_back(interval_row(10'd9, 10'd12, 1'b1));
        // An empty interval at the start of a set.
        directed_rows.push_back(interval_row(10'd3, 10'd3, 1'b0));
        directed_rows.push_back(interval_row(10'd0, 10'd2, 1'b0));
        directed_rows.push_back(interval_row(10'd1, 10'd5, 1'b0));
        directed_rows.push_back(interval_row(10'd2, 10'd3, 1'b1));
        // Nested and identical intervals.
        directed_rows.push_back(interval_row(10'd0, 10'd20, 1'b0));
        directed_rows.push_back(interval_row(10'd5, 10'd10, 1'b0));
        directed_rows.push_back(interval_row(10'd5, 10'd10, 1'b1));
        // Alternating bit patterns on both positions.
        directed_rows.push_back(interval_row(10'h155, 10'h2AA, 1'b0));
        directed_rows.push_back(interval_row(10'h2AA, 10'h3FF, 1'b1));

        foreach (directed_rows[i]) begin
            send_interval(directed_rows[i].start_pos, directed_rows[i].end_pos,
                          directed_rows[i].last);
            if (directed_rows[i].known_result)
                pending_assignments.push_back(directed_rows[i].result);
            load_interval(directed_rows[i].start_pos, directed_rows[i].end_pos,
                          directed_rows[i].last, !directed_rows[i].known_result);
        end

        // Random sets; set 2 always fills the table and set 5, if reached, overflows it.
        items_sent = 0;
        set_no     = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (set_no == 2)
                kind = SET_FULL;
            else if (set_no == 5)
                kind = SET_OVERFLOW;
            else begin
                case ($urandom_range(19))
                    0:       kind = SET_FULL;
                    1:       kind = SET_OVERFLOW;
                    2, 3:    kind = SET_WIDE;
                    default: kind = SET_NORMAL;
                endcase
            end
            case (kind)
                SET_WIDE:     begin count = $urandom_range(3, 1);   span = 1023; end
                SET_FULL:     begin count = TABLE_SIZE;             span = 15;   end
                SET_OVERFLOW: begin count = $urandom_range(68, 65); span = 15;   end
                default:      begin count = $urandom_range(8, 1);   span = 47;   end
            endcase
            for (int i = 0; i < count; i++) begin
                set_idling(items_sent);
                if (kind == SET_FULL && $urandom_range(1)) begin
                    // These intervals all overlap position 3, so many registers
                    // are live at once.
                    s = pos_t'($urandom_range(3));
                    e = pos_t'($urandom_range(15, 4));
                end else begin
                    s = pos_t'($urandom_range(span));
                    e = pos_t'($urandom_range(span));
                end
                send_interval(s, e, i == count - 1);
                load_interval(s, e, i == count - 1, 1'b1);
                items_sent++;
            end
            set_no++;
        end
        s_tvalid <= 1'b0;

        // Wait for the outstanding results, then a short drain.
        while (pending_assignments.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/lsra_pkg.sv
hw/rtl/lsra_table.sv
hw/rtl/lsra_alloc.sv
hw/rtl/linear_scan_register_assign.sv
tb/linear_scan_register_assign_test.sv
